FILE: rtl/sbmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmp_pkg
// Shared types, widths and codes of the shuffle bag mode picker.
// ----------------------------------------------------------------------------
package sbmp_pkg;

  // field and state widths
  localparam int ModeW   = 6;
  localparam int CountW  = 7;
  localparam int DurW    = 16;
  localparam int MaskW   = 64;
  localparam int RndW    = 32;
  localparam int ReqW    = 2;
  localparam int CfgIdxW = 2;

  // mode numbers of this value and above cannot be represented
  localparam int PoolDepthMax = 64;
  localparam int NumModesDflt = 64;

  // reset values
  localparam logic [CountW-1:0] SlotNone = '1;
  localparam logic [DurW-1:0]   DurReset = 16'd60;

  // request codes
  typedef enum logic [ReqW-1:0] {
    ReqStart = 2'd0,
    ReqTick  = 2'd1,
    ReqForce = 2'd2
  } req_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEnableMask = 2'd0,
    CfgSeqOrder   = 2'd1,
    CfgDuration   = 2'd2
  } cfg_idx_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic fill_init;
    logic fill_step;
    logic div_start;
    logic load_slot;
    logic rd_slot;
    logic repick;
    logic take;
    logic rd_tail;
    logic move;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic want_pick;
    logic pool_empty;
    logic fill_last;
    logic div_done;
    logic repick;
  } dp_status_t;

endpackage

FILE: rtl/sbmp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmp_div
// Serial remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module sbmp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sbmp_pkg::RndW-1:0]  dividend_i,
  input  logic [sbmp_pkg::CountW-1:0] divisor_i,
  output logic [sbmp_pkg::CountW-1:0] rem_o,
  output logic                       done_o
);

  localparam int CtrW = $clog2(sbmp_pkg::RndW);
  localparam logic [CtrW-1:0] CtrLast = CtrW'(sbmp_pkg::RndW - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CtrW-1:0]             ctr_q, ctr_d;
  logic [sbmp_pkg::RndW-1:0]   dvd_q, dvd_d;
  logic [sbmp_pkg::CountW-1:0] rem_q, rem_d;
  logic [sbmp_pkg::CountW:0]   trial;
  logic [sbmp_pkg::CountW:0]   diff;
  logic                        ge;

  // one shift and trial subtract per step
  always_comb begin
    trial = {rem_q, dvd_q[sbmp_pkg::RndW-1]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    ctr_d  = ctr_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      ctr_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[sbmp_pkg::CountW-1:0] : trial[sbmp_pkg::CountW-1:0];
      dvd_d = {dvd_q[sbmp_pkg::RndW-2:0], 1'b0};
      ctr_d = ctr_q + CtrW'(1);
      if (ctr_q == CtrLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ctr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ctr_q  <= ctr_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: rtl/sbmp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmp_dp
// Datapath: config registers, pool memory, counters and result registers.
// ----------------------------------------------------------------------------
module sbmp_dp #(
  parameter int NUM_MODES = sbmp_pkg::NumModesDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbmp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sbmp_pkg::MaskW-1:0]    cfg_wdata_i,
  input  logic [sbmp_pkg::ReqW-1:0]     req_type_i,
  input  logic [sbmp_pkg::RndW-1:0]     rnd_i,
  input  sbmp_pkg::ctl_cmd_t            cmd_i,
  output sbmp_pkg::dp_status_t          status_o,
  output logic [sbmp_pkg::ModeW-1:0]    mode_o,
  output logic                          changed_o,
  output logic                          valid_o
);

  localparam int ModeTotal = (NUM_MODES > sbmp_pkg::PoolDepthMax) ?
                             sbmp_pkg::PoolDepthMax : NUM_MODES;
  localparam int PaW = $clog2(ModeTotal);
  localparam logic [PaW-1:0] FillLast = PaW'(ModeTotal - 1);
  localparam logic [sbmp_pkg::MaskW-1:0] UsableMask =
    (ModeTotal >= sbmp_pkg::MaskW) ? {sbmp_pkg::MaskW{1'b1}} :
    ((sbmp_pkg::MaskW'(1) << ModeTotal) - sbmp_pkg::MaskW'(1));

  localparam int CW = sbmp_pkg::CountW;
  localparam int MW = sbmp_pkg::ModeW;
  localparam int DW = sbmp_pkg::DurW;

  // configuration
  logic [sbmp_pkg::MaskW-1:0] mask_q;
  logic                       seq_q;
  logic [DW-1:0]              dur_q;

  // control state
  logic [CW-1:0] count_q;
  logic [CW-1:0] last_pick_q;
  logic [CW-1:0] last_slot_q;
  logic [DW-1:0] elapsed_q;
  logic [MW-1:0] cur_mode_q;
  logic          changed_q;
  logic          valid_q;
  logic [PaW-1:0] fill_i_q;

  // payload
  logic [sbmp_pkg::RndW-1:0] rnd_q;
  logic [PaW-1:0]            slot_q;
  logic [MW-1:0]             pick_q;
  logic [MW-1:0]             rd_q;
  logic [MW-1:0]             pool_mem [ModeTotal];

  // combinational helpers
  logic [DW-1:0]             elapsed_inc;
  logic                      want_pick;
  logic                      any_en;
  logic                      fill_en;
  logic [CW-1:0]             prev1;
  logic [sbmp_pkg::RndW-1:0] dividend;
  logic [CW-1:0]             slot_inc;
  logic [PaW-1:0]            slot_adj;
  logic [CW-1:0]             tail;
  logic                      single;
  logic [CW-1:0]             rem;
  logic                      div_done;
  logic                      mem_we;
  logic [PaW-1:0]            mem_waddr;
  logic [MW-1:0]             mem_wdata;
  logic                      mem_re;
  logic [PaW-1:0]            mem_raddr;

  // timer and pick decision
  always_comb begin
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + DW'(1);
    case (req_type_i)
      sbmp_pkg::ReqStart, sbmp_pkg::ReqForce: want_pick = 1'b1;
      sbmp_pkg::ReqTick: want_pick = (dur_q != '0) && (elapsed_inc > dur_q);
      default: want_pick = 1'b0;
    endcase
  end

  // refill enable for the swept mode
  assign any_en  = |(mask_q & UsableMask);
  assign fill_en = any_en ? mask_q[fill_i_q] : 1'b1;

  // slot arithmetic
  assign single   = (count_q == CW'(1));
  assign prev1    = (last_slot_q == sbmp_pkg::SlotNone) ? '0 : last_slot_q + CW'(1);
  assign dividend = seq_q ? sbmp_pkg::RndW'(prev1) : rnd_q;
  assign slot_inc = CW'(slot_q) + CW'(1);
  assign slot_adj = (slot_inc == count_q) ? '0 : slot_inc[PaW-1:0];
  assign tail     = count_q - CW'(1);

  sbmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (count_q),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  // pool memory port muxing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = rd_q;
    if (cmd_i.fill_step && fill_en) begin
      mem_we    = 1'b1;
      mem_waddr = count_q[PaW-1:0];
      mem_wdata = MW'(fill_i_q);
    end else if (cmd_i.move) begin
      mem_we = 1'b1;
    end
    mem_re    = cmd_i.rd_slot || cmd_i.rd_tail;
    mem_raddr = cmd_i.rd_tail ? tail[PaW-1:0] : slot_q;
  end

  // pool memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= pool_mem[mem_raddr];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      seq_q  <= 1'b0;
      dur_q  <= sbmp_pkg::DurReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbmp_pkg::CfgEnableMask: mask_q <= cfg_wdata_i;
        sbmp_pkg::CfgSeqOrder:   seq_q  <= cfg_wdata_i[0];
        sbmp_pkg::CfgDuration:   dur_q  <= cfg_wdata_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // picker state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_pick_q <= sbmp_pkg::SlotNone;
      last_slot_q <= sbmp_pkg::SlotNone;
      elapsed_q   <= '0;
      cur_mode_q  <= '0;
      changed_q   <= 1'b0;
      valid_q     <= 1'b0;
      fill_i_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      if (cmd_i.accept) begin
        if (want_pick) begin
          elapsed_q <= '0;
        end else begin
          if (req_type_i == sbmp_pkg::ReqTick) begin
            elapsed_q <= elapsed_inc;
          end
          changed_q <= 1'b0;
          valid_q   <= 1'b1;
        end
      end
      if (cmd_i.fill_init) begin
        fill_i_q <= '0;
        count_q  <= '0;
      end
      if (cmd_i.fill_step) begin
        fill_i_q <= fill_i_q + PaW'(1);
        if (fill_en) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.move) begin
        count_q     <= tail;
        last_pick_q <= CW'(pick_q);
        if (single) begin
          last_slot_q <= sbmp_pkg::SlotNone;
        end else if (seq_q) begin
          last_slot_q <= CW'(slot_q);
        end
        cur_mode_q <= pick_q;
        changed_q  <= 1'b1;
        valid_q    <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rnd_q <= rnd_i;
    end
    if (cmd_i.load_slot) begin
      slot_q <= rem[PaW-1:0];
    end else if (cmd_i.repick) begin
      slot_q <= slot_adj;
    end
    if (cmd_i.take) begin
      pick_q <= rd_q;
    end
  end

  // status back to the controller
  assign status_o.want_pick  = want_pick;
  assign status_o.pool_empty = (count_q == '0);
  assign status_o.fill_last  = (fill_i_q == FillLast);
  assign status_o.div_done   = div_done;
  assign status_o.repick     = !seq_q && !single && (CW'(rd_q) == last_pick_q);

  assign mode_o    = cur_mode_q;
  assign changed_o = changed_q;
  assign valid_o   = valid_q;

endmodule

FILE: rtl/sbmp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmp_ctrl
// Controller: sequences refill, slot remainder, pool reads and the swap.
// ----------------------------------------------------------------------------
module sbmp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sbmp_pkg::dp_status_t status_i,
  output sbmp_pkg::ctl_cmd_t   cmd_o,
  output logic                 busy_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StFill  = 8'b0000_0010,
    StDivGo = 8'b0000_0100,
    StDiv   = 8'b0000_1000,
    StRd    = 8'b0001_0000,
    StChk   = 8'b0010_0000,
    StTail  = 8'b0100_0000,
    StMove  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.want_pick) begin
            if (status_i.pool_empty) begin
              cmd_o.fill_init = 1'b1;
              state_d = StFill;
            end else begin
              state_d = StDivGo;
            end
          end
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = StDivGo;
        end
      end
      StDivGo: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (status_i.div_done) begin
          cmd_o.load_slot = 1'b1;
          state_d = StRd;
        end
      end
      StRd: begin
        cmd_o.rd_slot = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        if (status_i.repick) begin
          cmd_o.repick = 1'b1;
          state_d = StRd;
        end else begin
          cmd_o.take = 1'b1;
          state_d = StTail;
        end
      end
      StTail: begin
        cmd_o.rd_tail = 1'b1;
        state_d = StMove;
      end
      StMove: begin
        cmd_o.move = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

FILE: rtl/shuffle_bag_mode_picker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffle_bag_mode_picker_top
// Picks the next mode from the enabled set, each once before any repeats.
// ----------------------------------------------------------------------------
//  channel   ports                                     direction
//  request   start_i, busy_o, req_type_i, rnd_i        in
//  result    valid_o, mode_o, changed_o                out
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          in
//
//  an item without a pick gives its result strobe in the cycle after accept
//  and busy_o never rises
//  a pick holds busy_o through the remainder, the pool reads and the swap,
//  with one more slot read per bump; a refill first sweeps every mode (at most 64)
//  the pick time is set by the 32-step serial remainder unit and the
//  one-entry-per-cycle refill sweep of the pool memory
//  reset clears all control state; the pool needs no clearing pass
//  results are not stalled: each strobe lasts exactly one cycle
// ----------------------------------------------------------------------------
module shuffle_bag_mode_picker_top #(
  parameter int NUM_MODES = sbmp_pkg::NumModesDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbmp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sbmp_pkg::MaskW-1:0]    cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [sbmp_pkg::ReqW-1:0]     req_type_i,
  input  logic [sbmp_pkg::RndW-1:0]     rnd_i,
  output logic                          valid_o,
  output logic [sbmp_pkg::ModeW-1:0]    mode_o,
  output logic                          changed_o
);

  sbmp_pkg::ctl_cmd_t   cmd;
  sbmp_pkg::dp_status_t status;

  // sequencer
  sbmp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath
  sbmp_dp #(
    .NUM_MODES (NUM_MODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .rnd_i       (rnd_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_o      (mode_o),
    .changed_o   (changed_o),
    .valid_o     (valid_o)
  );

`ifndef SYNTHESIS
  // a result beat only comes out while the picker is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy_o)
    else $error("result beat while busy");

  // the swap step always ends in a changed result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.move |=> (valid_o && changed_o))
    else $error("pick finished without a changed beat");

  // an accepted beat that needs a pick starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && status.want_pick) |=> (busy_o && !valid_o))
    else $error("pick request did not start the sequencer");

  // an accepted beat without a pick answers at once, unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !status.want_pick) |=> (valid_o && !changed_o))
    else $error("no-pick beat not answered next cycle");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shuffle bag mode picker. A clocked driver feeds
// request beats from a queue, keeps its own model of the bag, the elapsed
// counter and the current mode, and records the expected mode beat for each
// accepted request. A clocked monitor compares every result strobe with the
// oldest expected beat. The run covers directed corner cases, a short tick
// run under the largest duration, and randomized phases under varied
// enable masks, slot orders and durations.
// ----------------------------------------------------------------------------
module testbench;
  import sbmp_pkg::*;

  // codes outside the named sets
  localparam logic [ReqW-1:0]    ReqUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct {
    logic [ReqW-1:0] req;
    logic [RndW-1:0] rnd;
    int              gap;
    bit              drain;
  } req_beat_t;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic             changed;
  } mode_beat_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [MaskW-1:0]    cfg_wdata_i = '0;
  logic                start_i     = 1'b0;
  logic [ReqW-1:0]     req_type_i  = ReqStart;
  logic [RndW-1:0]     rnd_i       = '0;
  logic                busy_o;
  logic                valid_o;
  logic [ModeW-1:0]    mode_o;
  logic                changed_o;

  req_beat_t  req_beats_q[$];
  mode_beat_t mode_due_q[$];
  int         mismatches = 0;

  // picker model: configuration
  logic [MaskW-1:0]    mask_m = '0;
  logic                seq_m  = 1'b0;
  logic [DurW-1:0]     dur_m  = DurReset;
  // picker model: state
  logic [ModeW-1:0]    bag[PoolDepthMax];
  int unsigned         bag_count   = 0;
  logic [CountW-1:0]   last_pick_m = SlotNone;
  logic [CountW-1:0]   last_slot_m = SlotNone;
  logic [DurW-1:0]     elapsed_m   = '0;
  logic [ModeW-1:0]    cur_mode_m  = '0;

  shuffle_bag_mode_picker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_type_i (req_type_i),
    .rnd_i      (rnd_i),
    .valid_o    (valid_o),
    .mode_o     (mode_o),
    .changed_o  (changed_o)
  );

  always #2 clk_i = ~clk_i;

  // advance the picker model by one request and queue the expected beat
  function automatic void advance_picker(input logic [ReqW-1:0] req,
                                         input logic [RndW-1:0] rnd);
    bit               do_pick;
    int unsigned      fill;
    int unsigned      slot;
    int unsigned      next_slot;
    logic [ModeW-1:0] picked;
    do_pick = (req == ReqStart) || (req == ReqForce);
    if (req == ReqTick) begin
      if (elapsed_m != '1) elapsed_m = elapsed_m + 1'b1;
      if (dur_m != '0 && elapsed_m > dur_m) do_pick = 1'b1;
    end
    if (do_pick) begin
      // refill in ascending order once the bag runs dry
      if (bag_count == 0) begin
        fill = 0;
        for (int i = 0; i < PoolDepthMax; i++) begin
          if (mask_m[i]) begin
            bag[fill] = ModeW'(i);
            fill++;
          end
        end
        if (fill == 0) begin
          for (int i = 0; i < PoolDepthMax; i++) bag[i] = ModeW'(i);
          fill = PoolDepthMax;
        end
        bag_count = fill;
      end
      if (bag_count == 1) begin
        // last entry leaves the bag and resets the sequential slot
        last_slot_m = SlotNone;
        bag_count   = 0;
        picked      = bag[0];
      end else begin
        if (seq_m) begin
          next_slot   = (last_slot_m == SlotNone) ? 0 : last_slot_m + 1;
          slot        = next_slot % bag_count;
          last_slot_m = CountW'(slot);
        end else begin
          slot = rnd % bag_count;
          // never the same mode twice in a row: bump to the next slot
          if ({1'b0, bag[slot]} == last_pick_m) slot = (slot + 1) % bag_count;
        end
        picked    = bag[slot];
        bag[slot] = bag[bag_count-1];
        bag_count--;
      end
      last_pick_m = {1'b0, picked};
      cur_mode_m  = picked;
      elapsed_m   = '0;
    end
    mode_due_q.push_back('{mode: cur_mode_m, changed: do_pick});
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  // register write, mirrored into the model once it lands
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MaskW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgEnableMask: mask_m = value;
      CfgSeqOrder:   seq_m  = value[0];
      CfgDuration:   dur_m  = value[DurW-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_beat(input logic [ReqW-1:0] req, input logic [RndW-1:0] rnd,
                            input int gap, input bit drain);
    req_beats_q.push_back('{req: req, rnd: rnd, gap: gap, drain: drain});
  endtask

  // wait until every queued beat is accepted and answered, then settle
  task automatic drain_all();
    do @(negedge clk_i);
    while (req_beats_q.size() != 0 || start_i || mode_due_q.size() != 0 || busy_o);
    repeat (8) @(negedge clk_i);
  endtask

  // request driver
  bit        took;
  int        gap_left = 0;
  req_beat_t beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      req_type_i <= ReqStart;
      rnd_i      <= '0;
      gap_left   = 0;
    end else begin
      took = start_i && !busy_o;
      if (took) advance_picker(req_type_i, rnd_i);
      if (!start_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (req_beats_q.size() == 0 ||
                     (req_beats_q[0].drain && mode_due_q.size() != 0)) begin
          start_i <= 1'b0;
        end else begin
          beat       = req_beats_q.pop_front();
          start_i    <= 1'b1;
          req_type_i <= beat.req;
          rnd_i      <= beat.rnd;
          gap_left   = beat.gap;
        end
      end
    end
  end

  // result monitor
  mode_beat_t due;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (mode_due_q.size() == 0) begin
        flag_mismatch("unexpected result beat, mode", int'(mode_o), 0);
      end else begin
        due = mode_due_q.pop_front();
        if (mode_o !== due.mode) flag_mismatch("mode", int'(mode_o), int'(due.mode));
        if (changed_o !== due.changed) begin
          flag_mismatch("changed", int'(changed_o), int'(due.changed));
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [MaskW-1:0] mask;
    logic [DurW-1:0]  dur;
    int               r;
    int               gap;
    logic [ReqW-1:0]  req;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: unused code, ticks below the default duration
    queue_beat(ReqUnused, 32'h0, 0, 1'b0);
    queue_beat(ReqTick, 32'hFFFF_FFFF, 1, 1'b0);
    queue_beat(ReqTick, 32'h0, 0, 1'b0);
    drain_all();

    // single enabled mode repeats on every pick
    write_reg(CfgEnableMask, 64'h8000_0000_0000_0000);
    queue_beat(ReqStart, 32'h0, 0, 1'b0);
    queue_beat(ReqForce, 32'hFFFF_FFFF, 2, 1'b0);
    queue_beat(ReqForce, 32'h8000_0000, 0, 1'b0);
    drain_all();

    // two modes, sequential slots, short duration expiring on the third tick
    write_reg(CfgEnableMask, 64'h8000_0000_0000_0001);
    write_reg(CfgSeqOrder, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgDuration, 64'hFFFF_FFFF_FFFF_0002);
    write_reg(CfgUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_beat(ReqStart, 32'h0, 0, 1'b0);
    queue_beat(ReqStart, 32'h7FFF_FFFF, 0, 1'b0);
    queue_beat(ReqTick, 32'h0, 0, 1'b0);
    queue_beat(ReqTick, 32'h0, 1, 1'b0);
    queue_beat(ReqTick, 32'h5555_5555, 0, 1'b0);
    drain_all();

    // zero duration never changes by time
    write_reg(CfgDuration, 64'h0);
    queue_beat(ReqTick, 32'hAAAA_AAAA, 0, 1'b0);
    queue_beat(ReqTick, 32'h0, 0, 1'b0);
    drain_all();

    // full mask, random slots, duration of one
    write_reg(CfgEnableMask, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgSeqOrder, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CfgDuration, 64'h1);
    queue_beat(ReqForce, 32'h0, 0, 1'b0);
    queue_beat(ReqForce, 32'hFFFF_FFFF, 0, 1'b0);
    queue_beat(ReqStart, 32'h8000_0000, 0, 1'b0);
    queue_beat(ReqTick, 32'h0, 3, 1'b0);
    queue_beat(ReqTick, 32'h1234_5678, 0, 1'b0);
    drain_all();

    // back-to-back ticks under the largest duration never expire
    write_reg(CfgEnableMask, 64'h0);
    write_reg(CfgDuration, 64'hFFFF);
    for (int n = 0; n < 24; n++) queue_beat(ReqTick, $urandom, 0, 1'b0);
    drain_all();
    write_reg(CfgDuration, 64'h5);
    queue_beat(ReqTick, $urandom, 0, 1'b0);
    drain_all();

    // randomized phases
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: mask = '0;
        1: mask = '1;
        2: mask = 64'h1 << $urandom_range(0, 63);
        3: mask = {$urandom, $urandom};
        4: mask = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63));
        default: mask = {$urandom, $urandom} & ((64'h1 << $urandom_range(1, 8)) - 1);
      endcase
      case ($urandom_range(0, 7))
        0: dur = '0;
        1: dur = 16'd1;
        2: dur = '1;
        3: dur = 16'($urandom_range(7, 40));
        default: dur = 16'($urandom_range(2, 6));
      endcase
      write_reg(CfgEnableMask, mask);
      write_reg(CfgSeqOrder, {$urandom, $urandom});
      write_reg(CfgDuration, {$urandom, 16'($urandom_range(0, 65535)), dur});
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) req = ReqTick;
        else if (r < 75) req = ReqForce;
        else if (r < 93) req = ReqStart;
        else req = ReqUnused;
        // mostly short gaps, a few long ones
        r = $urandom_range(0, 99);
        if (r < 50) gap = 0;
        else if (r < 88) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 20);
        else gap = $urandom_range(21, 80);
        queue_beat(req, $urandom, gap, $urandom_range(0, 39) == 0);
      end
      drain_all();
    end

    // catch any stray result beat before closing
    repeat (120) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sbmp_pkg.sv
rtl/sbmp_div.sv
rtl/sbmp_dp.sv
rtl/sbmp_ctrl.sv
rtl/shuffle_bag_mode_picker_top.sv
tb/testbench.sv
